>>> hw/rtl/pfa_pkg.sv
// ============================================================================
// pfa_pkg - shared types and constants of the phase folding accumulator
// Profile geometry, register map, queue depths and the internal op word.
// ============================================================================
package pfa_pkg;

    // Profile geometry
    localparam int MAX_POLS       = 4;
    localparam int MAX_CHANNELS   = 256;
    localparam int MAX_PHASE_BINS = 256;

    localparam int POL_W  = (MAX_POLS > 1) ? $clog2(MAX_POLS) : 1;
    localparam int CHAN_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int BIN_W  = $clog2(MAX_PHASE_BINS);
    localparam int ADDR_W = POL_W + CHAN_W + BIN_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // Field and register widths
    localparam int VALUE_W     = 16;
    localparam int SUM_W       = 48;
    localparam int PHASE_W     = 48;
    localparam int CFG_BINS_W  = 9;
    localparam int CFG_CHANS_W = 9;
    localparam int CFG_POLS_W  = 3;

    // Widths that hold a clamped size as well as a counter plus one
    localparam int BIN_CMP_W  = (BIN_W + 1 > CFG_BINS_W) ? BIN_W + 1 : CFG_BINS_W;
    localparam int CHAN_CMP_W = (CHAN_W + 1 > CFG_CHANS_W) ? CHAN_W + 1 : CFG_CHANS_W;
    localparam int POL_CMP_W  = (POL_W + 1 > CFG_POLS_W) ? POL_W + 1 : CFG_POLS_W;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    typedef enum logic [1:0] {
        REG_NUM_BINS   = 2'd0,
        REG_NUM_CHANS  = 2'd1,
        REG_NUM_POLS   = 2'd2,
        REG_PHASE_STEP = 2'd3
    } reg_idx_t;

    localparam logic [CFG_BINS_W-1:0]  NUM_BINS_RST  = CFG_BINS_W'(256);
    localparam logic [CFG_CHANS_W-1:0] NUM_CHANS_RST = CFG_CHANS_W'(256);
    localparam logic [CFG_POLS_W-1:0]  NUM_POLS_RST  = CFG_POLS_W'(1);

    // Queues
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 4;
    localparam int OPTR_W      = $clog2(OUT_DEPTH);

    // Saturation limits
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic {
        OP_ACC  = 1'b0,
        OP_READ = 1'b1
    } op_kind_t;

    // One classified word handed from front to back
    typedef struct packed {
        op_kind_t                   kind;
        logic                       hit;
        logic [ADDR_W-1:0]          addr;
        logic signed [VALUE_W-1:0]  value;
    } op_t;

endpackage

>>> hw/rtl/pfa_stream_if.sv
// ============================================================================
// pfa_stream_if - valid/ready channels of the phase folding accumulator
// Input channel carries sample and read words, output channel carries sums.
// ============================================================================
interface pfa_in_if
    import pfa_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic signed [VALUE_W-1:0]  value;
    logic [1:0]                 read_pol;
    logic [7:0]                 read_chan;
    logic [7:0]                 read_bin;

    modport source (
        output valid, kind, value, read_pol, read_chan, read_bin,
        input  ready
    );

    modport sink (
        input  valid, kind, value, read_pol, read_chan, read_bin,
        output ready
    );
endinterface

interface pfa_out_if
    import pfa_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [SUM_W-1:0]  sum;

    modport source (
        output valid, sum,
        input  ready
    );

    modport sink (
        input  valid, sum,
        output ready
    );
endinterface

>>> hw/rtl/pfa_front.sv
// ============================================================================
// pfa_front - configuration registers, stream counters and classification
// Tracks channel, polarization and phase, turns each word into an op.
// ============================================================================
module pfa_front
    import pfa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    pfa_in_if.sink                 item,
    input  logic                   clearing,
    input  logic                   q_full,
    output logic                   push,
    output op_t                    push_op,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [CFG_BINS_W-1:0]   num_bins_reg;
    logic [CFG_CHANS_W-1:0]  num_chans_reg;
    logic [CFG_POLS_W-1:0]   num_pols_reg;
    logic [PHASE_W-1:0]      phase_step_reg;

    logic [CHAN_W-1:0]       chan_count_reg, chan_count_next;
    logic [POL_W-1:0]        pol_count_reg, pol_count_next;
    logic [PHASE_W-1:0]      phase_reg, phase_next;

    logic                    cfg_wr;
    reg_idx_t                reg_idx;
    logic                    accept;
    logic                    is_read;
    logic [BIN_CMP_W-1:0]    nb;
    logic [CHAN_CMP_W-1:0]   nc;
    logic [POL_CMP_W-1:0]    np;
    logic [BIN_CMP_W+PHASE_W-1:0] bin_prod;
    logic [BIN_CMP_W-1:0]    bin_raw;
    logic [BIN_CMP_W-1:0]    bin_sel;
    logic                    chan_last;
    logic                    pol_last;
    logic                    read_hit;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bins_reg   <= NUM_BINS_RST;
            num_chans_reg  <= NUM_CHANS_RST;
            num_pols_reg   <= NUM_POLS_RST;
            phase_step_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_NUM_BINS:   num_bins_reg   <= pwdata[CFG_BINS_W-1:0];
                REG_NUM_CHANS:  num_chans_reg  <= pwdata[CFG_CHANS_W-1:0];
                REG_NUM_POLS:   num_pols_reg   <= pwdata[CFG_POLS_W-1:0];
                REG_PHASE_STEP: phase_step_reg <= pwdata[PHASE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_NUM_BINS:   prdata = APB_DATA_W'(num_bins_reg);
            REG_NUM_CHANS:  prdata = APB_DATA_W'(num_chans_reg);
            REG_NUM_POLS:   prdata = APB_DATA_W'(num_pols_reg);
            REG_PHASE_STEP: prdata = APB_DATA_W'(phase_step_reg);
            default:        prdata = '0;
        endcase
    end

    // Zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (num_bins_reg == '0)
            nb = BIN_CMP_W'(1);
        else if (BIN_CMP_W'(num_bins_reg) > BIN_CMP_W'(MAX_PHASE_BINS))
            nb = BIN_CMP_W'(MAX_PHASE_BINS);
        else
            nb = BIN_CMP_W'(num_bins_reg);

        if (num_chans_reg == '0)
            nc = CHAN_CMP_W'(1);
        else if (CHAN_CMP_W'(num_chans_reg) > CHAN_CMP_W'(MAX_CHANNELS))
            nc = CHAN_CMP_W'(MAX_CHANNELS);
        else
            nc = CHAN_CMP_W'(num_chans_reg);

        if (num_pols_reg == '0)
            np = POL_CMP_W'(1);
        else if (POL_CMP_W'(num_pols_reg) > POL_CMP_W'(MAX_POLS))
            np = POL_CMP_W'(MAX_POLS);
        else
            np = POL_CMP_W'(num_pols_reg);
    end

    assign item.ready = !clearing && !q_full;
    assign accept     = item.valid && item.ready;
    assign is_read    = (op_kind_t'(item.kind) == OP_READ);

    // bin = floor(nb * phase), phase as 0.48 turns
    assign bin_prod = (BIN_CMP_W+PHASE_W)'(nb) * (BIN_CMP_W+PHASE_W)'(phase_reg);
    assign bin_raw  = bin_prod[BIN_CMP_W+PHASE_W-1:PHASE_W];
    assign bin_sel  = (bin_raw >= nb) ? nb - BIN_CMP_W'(1) : bin_raw;

    assign read_hit = (item.read_pol < MAX_POLS) && (item.read_chan < MAX_CHANNELS) &&
                      (item.read_bin < MAX_PHASE_BINS);

    assign chan_last = (CHAN_CMP_W'(chan_count_reg) + CHAN_CMP_W'(1)) >= nc;
    assign pol_last  = (POL_CMP_W'(pol_count_reg) + POL_CMP_W'(1)) >= np;

    always_comb
    begin
        push            = accept;
        push_op.kind    = is_read ? OP_READ : OP_ACC;
        push_op.value   = item.value;
        if (is_read)
        begin
            push_op.hit  = read_hit;
            push_op.addr = {POL_W'(item.read_pol), CHAN_W'(item.read_chan),
                            BIN_W'(item.read_bin)};
        end
        else
        begin
            push_op.hit  = 1'b1;
            push_op.addr = {pol_count_reg, chan_count_reg, bin_sel[BIN_W-1:0]};
        end

        chan_count_next = chan_count_reg;
        pol_count_next  = pol_count_reg;
        phase_next      = phase_reg;
        if (accept && !is_read)
        begin
            if (chan_last)
            begin
                chan_count_next = '0;
                if (pol_last)
                begin
                    pol_count_next = '0;
                    phase_next     = phase_reg + phase_step_reg;
                end
                else
                begin
                    pol_count_next = pol_count_reg + POL_W'(1);
                end
            end
            else
            begin
                chan_count_next = chan_count_reg + CHAN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg <= '0;
            pol_count_reg  <= '0;
            phase_reg      <= '0;
        end
        else
        begin
            chan_count_reg <= chan_count_next;
            pol_count_reg  <= pol_count_next;
            phase_reg      <= phase_next;
        end
    end

endmodule

>>> hw/rtl/pfa_queue.sv
// ============================================================================
// pfa_queue - short op queue between front and back
// Decouples classification from the read-modify-write pipeline.
// ============================================================================
module pfa_queue
    import pfa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  op_t   push_op,
    output logic  full,
    input  logic  pop,
    output op_t   head_op,
    output logic  empty
);

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head_op = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/pfa_back.sv
// ============================================================================
// pfa_back - profile memory with saturating read-modify-write
// Clears the memory after reset, accumulates, reads and clears entries.
// ============================================================================
module pfa_back
    import pfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  op_t         head_op,
    output logic        pop,
    output logic        clearing,
    pfa_out_if.source   result
);

    logic [SUM_W-1:0]  mem [MEM_DEPTH];

    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [SUM_W-1:0]  rd_data_reg;

    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [SUM_W-1:0]  fwd_data_reg;

    logic [SUM_W-1:0]  ofifo_reg [OUT_DEPTH];
    logic [OPTR_W-1:0] owr_ptr_reg;
    logic [OPTR_W-1:0] ord_ptr_reg;
    logic [OPTR_W:0]   ocount_reg, ocount_next;

    logic                     s1_read;
    logic                     s1_we;
    logic signed [SUM_W-1:0]  old_sum;
    logic signed [SUM_W:0]    wide_sum;
    logic signed [SUM_W-1:0]  sat_sum;
    logic [SUM_W-1:0]         new_data;
    logic                     opush;
    logic [SUM_W-1:0]         opush_data;
    logic                     opop;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [SUM_W-1:0]         mem_wdata;

    assign clearing = clearing_reg;

    assign s1_read = s1_valid_reg && (s1_op_reg.kind == OP_READ);
    assign s1_we   = s1_valid_reg && s1_op_reg.hit;

    // Hold back reads while the output side could overflow
    assign pop = !clearing_reg && !q_empty &&
                 ((head_op.kind == OP_ACC) ||
                  ((ocount_reg + (OPTR_W+1)'(s1_read)) < (OPTR_W+1)'(OUT_DEPTH)));

    // Forward the write made at the edge that read this entry
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_op_reg.addr))
            old_sum = fwd_data_reg;
        else
            old_sum = rd_data_reg;

        wide_sum = {old_sum[SUM_W-1], old_sum} + (SUM_W+1)'(s1_op_reg.value);
        if (wide_sum > (SUM_W+1)'(SUM_MAX))
            sat_sum = SUM_MAX;
        else if (wide_sum < (SUM_W+1)'(SUM_MIN))
            sat_sum = SUM_MIN;
        else
            sat_sum = wide_sum[SUM_W-1:0];

        new_data   = (s1_op_reg.kind == OP_ACC) ? sat_sum : '0;
        opush      = s1_read;
        opush_data = s1_op_reg.hit ? old_sum : '0;
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s1_we;
            mem_waddr = s1_op_reg.addr;
            mem_wdata = new_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (pop)
            rd_data_reg <= mem[head_op.addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1))
                    clearing_reg <= 1'b0;
            end
            s1_valid_reg  <= pop;
            fwd_valid_reg <= s1_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            s1_op_reg <= head_op;
        fwd_addr_reg <= s1_op_reg.addr;
        fwd_data_reg <= new_data;
    end

    // Output FIFO
    assign result.valid = (ocount_reg != '0);
    assign result.sum   = ofifo_reg[ord_ptr_reg];
    assign opop         = result.valid && result.ready;
    assign ocount_next  = ocount_reg + (OPTR_W+1)'(opush) - (OPTR_W+1)'(opop);

    always_ff @(posedge clk)
    begin
        if (opush)
            ofifo_reg[owr_ptr_reg] <= opush_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocount_reg  <= '0;
        end
        else
        begin
            if (opush)
                owr_ptr_reg <= owr_ptr_reg + OPTR_W'(1);
            if (opop)
                ord_ptr_reg <= ord_ptr_reg + OPTR_W'(1);
            ocount_reg <= ocount_next;
        end
    end

endmodule

>>> hw/rtl/phase_folding_accumulator_core.sv
// ============================================================================
// phase_folding_accumulator_core - epoch folding of a channelized stream
// Folds sample words into a per (pol, chan, bin) profile and reads it back.
// ============================================================================
// Throughput: one word per cycle, accumulate and read words alike, while
// item.ready is high (low while the profile is cleared or the queue is full);
// reads also wait for room in the output FIFO. The profile memory's
// read-modify-write pipeline sets the rate. Reset: counters, phase and queues
// clear at once; registers take defaults. Then the 2^18 = 262144 entries
// are zeroed one per cycle, item.ready low; register writes are taken meanwhile.
// ============================================================================
module phase_folding_accumulator_core
    import pfa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    pfa_in_if.sink                 item,
    pfa_out_if.source              result,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    // Front to queue
    logic  push;
    op_t   push_op;
    logic  q_full;

    // Queue to back
    logic  pop;
    op_t   head_op;
    logic  q_empty;

    // Back status: high while the profile memory is swept to zero
    logic  clearing;

    // Front: register file, channel/pol/phase tracking, bin lookup.
    // Each accepted word becomes one op: an accumulate at the current
    // (pol, chan, bin), or a read-and-clear of the requested entry.
    pfa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .clearing (clearing),
        .q_full   (q_full),
        .push     (push),
        .push_op  (push_op),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Short queue: lets the front keep taking words while the back
    // waits for room in its output FIFO.
    pfa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .head_op (head_op),
        .empty   (q_empty)
    );

    // Back: memory read on pop, saturating update and write in the following
    // cycle, with a forwarding path for back-to-back hits on one entry.
    pfa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .head_op  (head_op),
        .pop      (pop),
        .clearing (clearing),
        .result   (result)
    );

endmodule

>>> hw/rtl/pfa_checker.sv
// ============================================================================
// pfa_checker - port-level checks of the phase folding accumulator
// Watches the channels and the register port of the top level.
// ============================================================================
module pfa_checker
    import pfa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_ready,
    input  logic                   item_kind,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  logic [SUM_W-1:0]       result_sum,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    input  logic [APB_DATA_W-1:0]  prdata
);

    logic [4:0] outstanding_reg, outstanding_next;
    logic       rd_in;
    logic       rd_out;

    assign rd_in  = item_valid && item_ready && (op_kind_t'(item_kind) == OP_READ);
    assign rd_out = result_valid && result_ready;
    assign outstanding_next = outstanding_reg + 5'(rd_in) - 5'(rd_out);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= '0;
        else
            outstanding_reg <= outstanding_next;
    end

    // Hold a stalled result word
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_sum))
        else $error("stalled result word changed");

    // Every result answers an earlier read word
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> outstanding_reg != '0)
        else $error("result word without a pending read");

    // Keep input closed right after reset while the profile is swept
    a_sweep_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !item_ready)
        else $error("input open during profile sweep");

    // Read back a phase step that was just written
    a_step_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[APB_ADDR_W-1:3] == REG_PHASE_STEP)
        ##1 (paddr[APB_ADDR_W-1:3] == REG_PHASE_STEP)
        |-> prdata == APB_DATA_W'($past(pwdata[PHASE_W-1:0])))
        else $error("phase step readback mismatch");

endmodule

bind phase_folding_accumulator_core pfa_checker u_pfa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_kind    (item.kind),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_sum   (result.sum),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);

>>> test/phase_folding_accumulator_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// phase_folding_accumulator_core_tb - self-checking bench of the folding core
// Drives sample and read words over valid/ready with random idling on both
// sides, programs the geometry and phase step over APB between phases, and
// checks every returned sum against a bit-accurate fold of the same stream.
// ============================================================================
module phase_folding_accumulator_core_tb;
    import pfa_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 8;
    // Extra wait after the last sum for sample words still in flight
    localparam int SETTLE_CYCLES = 8;
    // Receiver hold-off long enough to back the block up into its input
    localparam int LONG_HOLD     = 200;
    // Covers the post-reset clearing pass over 2^18 entries, with nothing taken
    localparam int QUIET_LIMIT   = 1000000;
    localparam int MIXED_WORDS   = 150;

    // One word on the input channel
    typedef struct {
        op_kind_t                  kind;
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                pol;
        logic [7:0]                chan;
        logic [7:0]                bin;
    } fold_word_t;

    // ------------------------------------------------------------------------
    // Profile fold tracker: own copy of counters, phase, registers and the
    // profile memory; keeps the sums owed for read words not yet answered.
    // ------------------------------------------------------------------------
    class fold_tracker;
        logic signed [SUM_W-1:0] profile [int];
        logic signed [SUM_W-1:0] owed_sums [$];
        logic [PHASE_W-1:0]      phase_acc;
        logic [PHASE_W-1:0]      phase_step;
        int unsigned             chan_cnt;
        int unsigned             pol_cnt;
        int unsigned             num_bins;
        int unsigned             num_chans;
        int unsigned             num_pols;
        int                      errors;

        function new();
            phase_acc  = '0;
            phase_step = '0;
            chan_cnt   = 0;
            pol_cnt    = 0;
            num_bins   = NUM_BINS_RST;
            num_chans  = NUM_CHANS_RST;
            num_pols   = NUM_POLS_RST;
            errors     = 0;
        endfunction

        // Zero acts as one, oversize acts as the memory's maximum
        function int unsigned clamp_size(int unsigned v, int unsigned top);
            if (v == 0)
                return 1;
            return (v > top) ? top : v;
        endfunction

        function int unsigned bins_eff();
            return clamp_size(num_bins, MAX_PHASE_BINS);
        endfunction

        function int unsigned chans_eff();
            return clamp_size(num_chans, MAX_CHANNELS);
        endfunction

        function int unsigned pols_eff();
            return clamp_size(num_pols, MAX_POLS);
        endfunction

        function void set_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] v);
            case (idx)
                REG_NUM_BINS:   num_bins   = v[CFG_BINS_W-1:0];
                REG_NUM_CHANS:  num_chans  = v[CFG_CHANS_W-1:0];
                REG_NUM_POLS:   num_pols   = v[CFG_POLS_W-1:0];
                REG_PHASE_STEP: phase_step = v[PHASE_W-1:0];
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // Apply one accepted word to the profile
        function void fold_word(fold_word_t w);
            int unsigned             nb;
            int unsigned             nc;
            int unsigned             np;
            int unsigned             bin;
            logic [63:0]             prod;
            int                      key;
            logic signed [SUM_W:0]   s;
            logic signed [SUM_W-1:0] old;

            if (w.kind == OP_READ) begin
                // Read fields are never wider than the memory, so every read
                // lands on a real entry
                key = {w.pol, w.chan, w.bin};
                old = '0;
                if (profile.exists(key))
                    old = profile[key];
                owed_sums.push_back(old);
                profile.delete(key);
                return;
            end

            nb   = bins_eff();
            nc   = chans_eff();
            np   = pols_eff();
            prod = 64'(nb) * 64'(phase_acc);
            bin  = prod[63:PHASE_W];
            if (bin >= nb)
                bin = nb - 1;
            key = {pol_cnt[POL_W-1:0], chan_cnt[CHAN_W-1:0], bin[BIN_W-1:0]};

            s = '0;
            if (profile.exists(key))
                s = profile[key];
            s = s + w.value;
            if (s > SUM_MAX)
                s = SUM_MAX;
            if (s < SUM_MIN)
                s = SUM_MIN;
            profile[key] = s[SUM_W-1:0];

            // Counters past a shrunk size wrap as if at the last position
            if (chan_cnt + 1 >= nc) begin
                chan_cnt = 0;
                if (pol_cnt + 1 >= np) begin
                    pol_cnt   = 0;
                    phase_acc = phase_acc + phase_step;
                end else begin
                    pol_cnt++;
                end
            end else begin
                chan_cnt++;
            end
        endfunction

        task check_sum(logic signed [SUM_W-1:0] got);
            logic signed [SUM_W-1:0] want;
            if (owed_sums.size() == 0) begin
                report($sformatf("sum %0d returned with no read pending", got));
                return;
            end
            want = owed_sums.pop_front();
            if (got !== want)
                report($sformatf("sum %0d, expected %0d", got, want));
        endtask

        function int owed();
            return owed_sums.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, APB and the block itself
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pfa_in_if  item_if ();
    pfa_out_if result_if ();

    fold_tracker tracker;

    int tx_run       = 0;   // words left in a no-idle stretch on the sender
    int rx_run       = 0;   // same for the receiver
    int quiet_cycles = 0;
    bit eager        = 1'b0; // sender offers back to back
    bit stall_req    = 1'b0; // ask the receiver for one long hold-off

    always #(CLK_PERIOD / 2) clk = ~clk;

    phase_folding_accumulator_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Helpers for building words and idling
    // ------------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one; a small
    // chance opens a stretch with no idling at all
    function automatic int idle_len(inout int run);
        int r;
        if (run > 0) begin
            run--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            run = $urandom_range(16, 64);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Read fields are don't-care on a sample word; fill them with noise
    function automatic fold_word_t acc_of(logic signed [VALUE_W-1:0] v);
        fold_word_t w;
        w.kind  = OP_ACC;
        w.value = v;
        w.pol   = 2'($urandom);
        w.chan  = 8'($urandom);
        w.bin   = 8'($urandom);
        return w;
    endfunction

    function automatic fold_word_t read_at(int p, int c, int b);
        fold_word_t w;
        w.kind  = OP_READ;
        w.value = VALUE_W'($urandom);
        w.pol   = 2'(p);
        w.chan  = 8'(c);
        w.bin   = 8'(b);
        return w;
    endfunction

    // Mostly full-range noise, sometimes the extremes
    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 19))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic [PHASE_W-1:0] rand_step();
        return PHASE_W'({$urandom, $urandom});
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one word and hold it until taken; valid stays high on return so
    // the next word can follow without a bubble
    task automatic push_word(fold_word_t w);
        int gap;
        gap = eager ? 0 : idle_len(tx_run);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid     <= 1'b1;
        item_if.kind      <= w.kind;
        item_if.value     <= w.value;
        item_if.read_pol  <= w.pol;
        item_if.read_chan <= w.chan;
        item_if.read_bin  <= w.bin;
        do @(posedge clk); while (!item_if.ready);
    endtask

    // Drop valid, let the monitor note the last word, wait out every owed
    // sum, then let sample words in flight land before anything touches
    // the registers
    task automatic settle();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (tracker.owed() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write, then read back the same register
    task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] v);
        logic [APB_DATA_W-1:0] mask;
        logic [APB_DATA_W-1:0] got;
        case (idx)
            REG_NUM_BINS:   mask = (64'd1 << CFG_BINS_W) - 64'd1;
            REG_NUM_CHANS:  mask = (64'd1 << CFG_CHANS_W) - 64'd1;
            REG_NUM_POLS:   mask = (64'd1 << CFG_POLS_W) - 64'd1;
            default:        mask = (64'd1 << PHASE_W) - 64'd1;
        endcase

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.set_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);

        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== (v & mask))
            tracker.report($sformatf("register %s reads 0x%0h, wrote 0x%0h",
                                     idx.name(), got, v & mask));
    endtask

    task automatic apply_config(int unsigned b, int unsigned c, int unsigned p,
                                logic [PHASE_W-1:0] step);
        write_reg(REG_NUM_BINS, b);
        write_reg(REG_NUM_CHANS, c);
        write_reg(REG_NUM_POLS, p);
        write_reg(REG_PHASE_STEP, step);
    endtask

    // Random mix: about a third reads, most of them aimed inside the
    // configured geometry so they find folded data, the rest anywhere
    task automatic run_mixed(int count);
        fold_word_t w;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 35) begin
                if ($urandom_range(0, 99) < 85)
                    w = read_at($urandom_range(0, tracker.pols_eff() - 1),
                                $urandom_range(0, tracker.chans_eff() - 1),
                                $urandom_range(0, tracker.bins_eff() - 1));
                else
                    w = read_at($urandom_range(0, 3), $urandom_range(0, 255),
                                $urandom_range(0, 255));
            end else begin
                w = acc_of(rand_value());
            end
            push_word(w);
        end
    endtask

    task automatic run_phase(int unsigned b, int unsigned c, int unsigned p,
                             logic [PHASE_W-1:0] step, bit squeeze);
        settle();
        apply_config(b, c, p, step);
        if (squeeze) begin
            stall_req = 1'b1;
            eager     = 1'b1;
        end
        run_mixed(MIXED_WORDS);
        eager = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Monitors: note each accepted word, check each accepted sum
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (result_if.valid && result_if.ready)
                tracker.check_sum(result_if.sum);
            if (item_if.valid && item_if.ready)
                tracker.fold_word(fold_word_t'{op_kind_t'(item_if.kind), item_if.value,
                                               item_if.read_pol, item_if.read_chan,
                                               item_if.read_bin});
        end
    end

    // Watchdog: count cycles in which no word, sum or register access moves
    always @(posedge clk) begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
            (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, stretches of steady ready, and on request one
    // long hold-off so the block fills and pushes back on its input
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (stall_req) begin
                stall_req = 1'b0;
                result_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                gap = idle_len(rx_run);
                if (gap > 0) begin
                    result_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                result_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        rst_n             = 1'b0;
        item_if.valid     = 1'b0;
        item_if.kind      = OP_ACC;
        item_if.value     = '0;
        item_if.read_pol  = '0;
        item_if.read_chan = '0;
        item_if.read_bin  = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        tracker           = new();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Program a small geometry while the profile is still being cleared:
        // 4 bins, 3 channels, 2 pols, a quarter turn per sample
        apply_config(4, 3, 2, 48'h4000_0000_0000);

        // Directed: two full samples of extreme values, back to back
        eager = 1'b1;
        push_word(acc_of(16'sh7FFF));   // sample 0, bin 0
        push_word(acc_of(16'sh8000));
        push_word(acc_of(16'sh0000));
        push_word(acc_of(16'shFFFF));
        push_word(acc_of(16'sh0001));
        push_word(acc_of(16'sh7FFF));
        push_word(acc_of(16'sh7FFF));   // sample 1, bin 1
        push_word(acc_of(16'sh7FFF));
        push_word(acc_of(16'sh8000));
        push_word(acc_of(16'sh8000));
        push_word(acc_of(16'sh5555));
        push_word(acc_of(16'shAAAA));
        // Read back and clear, then read a cleared entry again
        push_word(read_at(0, 0, 0));
        push_word(read_at(0, 1, 0));
        push_word(read_at(1, 2, 0));
        push_word(read_at(0, 0, 1));
        push_word(read_at(1, 2, 1));
        push_word(read_at(0, 0, 0));
        // Entry outside the configured geometry, at the field extremes
        push_word(read_at(3, 255, 255));
        // Sample word then an immediate read of the entry it just hit
        push_word(acc_of(16'sd100));    // sample 2, bin 2, pol 0 chan 0
        push_word(read_at(0, 0, 2));
        push_word(read_at(0, 1, 2));
        eager = 1'b0;

        // Counters beyond a shrunk geometry: park the counters at pol 1
        // chan 101 under the full channel count, then shrink to 4 channels
        // and 1 pol so the next sample lands there and both counters wrap
        settle();
        apply_config(1, 256, 4, rand_step());
        repeat (MAX_CHANNELS + 100) push_word(acc_of(rand_value()));
        settle();
        apply_config(1, 4, 1, rand_step());
        repeat (3) push_word(acc_of(rand_value()));
        push_word(read_at(1, 100, 0));
        push_word(read_at(1, 99, 0));
        push_word(read_at(0, 0, 0));
        push_word(read_at(0, 1, 0));
        push_word(read_at(1, 0, 0));

        // Random phases across settings: zero sizes, oversize registers,
        // full sizes, and both ends of the phase step
        run_phase(4, 3, 2, 48'h4000_0000_0000, 1'b1);
        run_phase(0, 0, 0, rand_step(), 1'b0);
        run_phase(511, 7, 7, 48'hFFFF_FFFF_FFFF, 1'b0);
        run_phase(256, 256, 1, 48'h0, 1'b0);
        run_phase(1, 1, 4, rand_step(), 1'b0);
        run_phase(13, 5, 3, rand_step(), 1'b0);
        run_phase(256, 2, 4, rand_step(), 1'b0);
        run_phase(6, 511, 2, rand_step(), 1'b0);

        settle();
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
